// File: design/jsu_pkg.sv
// Shared types for the JSON string unescape block: job words, error codes, queue status.
package jsu_pkg;

   // Error codes carried on the result port
   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_NO_QUOTE    = 4'd1,
      ERR_CONTROL     = 4'd2,
      ERR_INCOMPLETE  = 4'd3,
      ERR_BAD_UNICODE = 4'd4,
      ERR_MISSING_LOW = 4'd5,
      ERR_BAD_LOW     = 4'd6,
      ERR_UNKNOWN_ESC = 4'd7,
      ERR_UNTERM      = 4'd8
   } err_type;

   // What the back end has to produce for one input byte
   typedef enum logic [1:0] {
      JOB_BYTE = 2'd0,   // one raw byte, in cp[7:0]
      JOB_CP   = 2'd1,   // code point, encoded as 1..4 UTF-8 bytes
      JOB_DONE = 2'd2,   // closing quote
      JOB_ERR  = 2'd3    // error word
   } job_kind_type;

   localparam int CP_W = 21;

   typedef struct packed {
      job_kind_type    kind;
      logic [CP_W-1:0] cp;
      err_type         err;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

// File: design/jsu_front.sv
// Front end: tracks the string/escape state and turns each input byte into a job.
module jsu_front
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       end_marker,
   output logic       job_push,
   output job_type    job_data
);

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_STR  = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX1 = 3'd3,
      PH_BSL  = 3'd4,
      PH_ULOW = 3'd5,
      PH_HEX2 = 3'd6
   } phase_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [5:0] SURR_HI   = 6'b110110;  // D800..DBFF
   localparam logic [5:0] SURR_LO   = 6'b110111;  // DC00..DFFF
   localparam logic [CP_W-1:0] PLANE1 = 21'h10000;

   // {ok, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [11:0] hex_ff, hex_in;      // first three digits of a group
   logic [1:0]  digit_ff, digit_in;
   logic [9:0]  high_ff, high_in;    // high surrogate minus D800

   logic [4:0]  dig;
   logic [15:0] full;
   logic        fail;
   err_type     fail_code;

   assign dig  = hex_digit(data_byte);
   assign full = {hex_ff, dig[3:0]};

   always_comb begin
      phase_in  = phase_ff;
      hex_in    = hex_ff;
      digit_in  = digit_ff;
      high_in   = high_ff;
      job_push  = 1'b0;
      job_data  = '{kind: JOB_BYTE, cp: '0, err: ERR_NONE};
      fail      = 1'b0;
      fail_code = ERR_NONE;
      if (accept) begin
         if (end_marker) begin
            unique case (phase_ff)
               PH_STR:            begin fail = 1'b1; fail_code = ERR_UNTERM;      end
               PH_ESC:            begin fail = 1'b1; fail_code = ERR_INCOMPLETE;  end
               PH_HEX1:           begin fail = 1'b1; fail_code = ERR_BAD_UNICODE; end
               PH_BSL, PH_ULOW:   begin fail = 1'b1; fail_code = ERR_MISSING_LOW; end
               PH_HEX2:           begin fail = 1'b1; fail_code = ERR_BAD_LOW;     end
               default:           phase_in = PH_WAIT;
            endcase
         end else begin
            unique case (phase_ff)
               PH_STR: begin
                  priority if (data_byte == CH_QUOTE) begin
                     phase_in = PH_WAIT;
                     hex_in   = '0;
                     digit_in = '0;
                     high_in  = '0;
                     job_push = 1'b1;
                     job_data.kind = JOB_DONE;
                  end else if (data_byte < CH_SPACE) begin
                     fail = 1'b1; fail_code = ERR_CONTROL;
                  end else if (data_byte == CH_BSLASH) begin
                     phase_in = PH_ESC;
                  end else begin
                     job_push = 1'b1;
                     job_data.cp = {{(CP_W-8){1'b0}}, data_byte};
                  end
               end
               PH_ESC: begin
                  phase_in = PH_STR;
                  job_push = 1'b1;
                  unique case (data_byte)
                     CH_QUOTE, CH_BSLASH, CH_SLASH:
                        job_data.cp = {{(CP_W-8){1'b0}}, data_byte};
                     CH_B: job_data.cp = 21'h08;
                     CH_F: job_data.cp = 21'h0c;
                     CH_N: job_data.cp = 21'h0a;
                     CH_R: job_data.cp = 21'h0d;
                     CH_T: job_data.cp = 21'h09;
                     CH_U: begin
                        job_push = 1'b0;
                        phase_in = PH_HEX1;
                        hex_in   = '0;
                        digit_in = '0;
                     end
                     default: begin
                        job_push = 1'b0;
                        fail = 1'b1; fail_code = ERR_UNKNOWN_ESC;
                     end
                  endcase
               end
               PH_HEX1, PH_HEX2: begin
                  if (!dig[4]) begin
                     fail = 1'b1;
                     fail_code = (phase_ff == PH_HEX1) ? ERR_BAD_UNICODE : ERR_BAD_LOW;
                  end else if (digit_ff != 2'd3) begin
                     hex_in   = {hex_ff[7:0], dig[3:0]};
                     digit_in = digit_ff + 2'd1;
                  end else begin
                     digit_in = '0;
                     hex_in   = '0;
                     if (phase_ff == PH_HEX1) begin
                        if (full[15:10] == SURR_HI) begin
                           high_in  = full[9:0];
                           phase_in = PH_BSL;
                        end else begin
                           phase_in = PH_STR;
                           job_push = 1'b1;
                           job_data.kind = JOB_CP;
                           job_data.cp   = {{(CP_W-16){1'b0}}, full};
                        end
                     end else if (full[15:10] != SURR_LO) begin
                        fail = 1'b1; fail_code = ERR_BAD_LOW;
                     end else begin
                        phase_in = PH_STR;
                        high_in  = '0;
                        job_push = 1'b1;
                        job_data.kind = JOB_CP;
                        job_data.cp   = PLANE1 + {1'b0, high_ff, full[9:0]};
                     end
                  end
               end
               PH_BSL: begin
                  if (data_byte != CH_BSLASH) begin
                     fail = 1'b1; fail_code = ERR_MISSING_LOW;
                  end else begin
                     phase_in = PH_ULOW;
                  end
               end
               PH_ULOW: begin
                  if (data_byte != CH_U) begin
                     fail = 1'b1; fail_code = ERR_MISSING_LOW;
                  end else begin
                     phase_in = PH_HEX2;
                     hex_in   = '0;
                     digit_in = '0;
                  end
               end
               default: begin
                  // waiting for an opening quote (also covers unused codes)
                  if (data_byte == CH_QUOTE) begin
                     phase_in = PH_STR;
                     hex_in   = '0;
                     digit_in = '0;
                     high_in  = '0;
                  end else begin
                     phase_in = PH_WAIT;
                     job_push = 1'b1;
                     job_data.kind = JOB_ERR;
                     job_data.err  = ERR_NO_QUOTE;
                  end
               end
            endcase
         end
         if (fail) begin
            phase_in = PH_WAIT;
            hex_in   = '0;
            digit_in = '0;
            high_in  = '0;
            job_push = 1'b1;
            job_data = '{kind: JOB_ERR, cp: '0, err: fail_code};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         hex_ff   <= '0;
         digit_ff <= '0;
         high_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         digit_ff <= digit_in;
         high_ff  <= high_in;
      end
   end

   // high half only lives between the two escapes of a pair
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_BSL && phase_ff != PH_ULOW && phase_ff != PH_HEX2) |-> high_ff == '0)
      else $error("jsu_front: stale high surrogate");

endmodule

// File: design/jsu_fifo.sv
// Job queue between front and back end: show-ahead, flip-flop storage.
module jsu_fifo
   import jsu_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  job_type         push_data,
   input  logic            pop,
   output job_type         head,
   output fifo_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   job_type       store_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_COUNT);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = store_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop  ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("jsu_fifo: count overflow");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> wr_ff == rd_ff)
      else $error("jsu_fifo: pointers disagree with count");

endmodule

// File: design/jsu_back.sv
// Back end: expands the head job into output register words, one per cycle unless stalled.
module jsu_back
   import jsu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  job_type         head,
   input  fifo_status_type status,
   output logic            job_pop,
   input  logic            rsp_pop,
   output logic            rsp_empty,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_string_done,
   output logic [3:0]      rsp_error_code,
   output logic            rsp_last_of_run
);

   logic [1:0]      idx_ff, idx_in;
   logic [1:0]      last_idx;
   logic [3:0][7:0] enc;
   logic            load, word_last;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      byte_ff, byte_in;
   logic            bvalid_ff, bvalid_in;
   logic            done_ff, done_in;
   err_type         err_ff, err_in;
   logic            last_ff, last_in;
   logic [CP_W-1:0] cp;

   assign cp = head.cp;

   // number of bytes minus one, and the bytes themselves
   always_comb begin
      enc = '0;
      if (head.kind != JOB_CP || cp <= 21'h7f) begin
         last_idx = 2'd0;
         enc[0]   = cp[7:0];
      end else if (cp <= 21'h7ff) begin
         last_idx = 2'd1;
         enc[0]   = {3'b110, cp[10:6]};
         enc[1]   = {2'b10, cp[5:0]};
      end else if (cp <= 21'hffff) begin
         last_idx = 2'd2;
         enc[0]   = {4'b1110, cp[15:12]};
         enc[1]   = {2'b10, cp[11:6]};
         enc[2]   = {2'b10, cp[5:0]};
      end else begin
         last_idx = 2'd3;
         enc[0]   = {5'b11110, cp[20:18]};
         enc[1]   = {2'b10, cp[17:12]};
         enc[2]   = {2'b10, cp[11:6]};
         enc[3]   = {2'b10, cp[5:0]};
      end
   end

   assign load      = !status.empty && (!out_valid_ff || rsp_pop);
   assign word_last = (idx_ff == last_idx);
   assign job_pop   = load && word_last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      byte_in      = byte_ff;
      bvalid_in    = bvalid_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      if (load) begin
         idx_in       = word_last ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
         last_in      = word_last;
         unique case (head.kind)
            JOB_BYTE, JOB_CP: begin
               byte_in = enc[idx_ff]; bvalid_in = 1'b1; done_in = 1'b0; err_in = ERR_NONE;
            end
            JOB_DONE: begin
               byte_in = '0; bvalid_in = 1'b0; done_in = 1'b1; err_in = ERR_NONE;
            end
            JOB_ERR: begin
               byte_in = '0; bvalid_in = 1'b0; done_in = 1'b0; err_in = head.err;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      done_ff   <= done_in;
      err_ff    <= err_in;
      last_ff   <= last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_string_done = done_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_last_of_run = last_ff;

   // only a multi-byte code point is ever taken apart into several result words
   assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> (!status.empty && head.kind == JOB_CP))
      else $error("jsu_back: partial job lost");

   // done and error words stand alone and carry no byte
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (done_ff || err_ff != ERR_NONE)) |-> (!bvalid_ff && last_ff))
      else $error("jsu_back: malformed status word");

endmodule

// File: design/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: front end, job queue, UTF-8 back end.
//
// Decodes one quoted JSON string per run, one input word (a raw byte or an
// end-of-text marker) per cycle. The input side accepts a word on every cycle
// that req_full is low; the front end updates the escape state at once and
// queues at most one job per word. The back end turns each job into one to
// four result words on the rsp_ side, one word per cycle while rsp_pop keeps
// the output register free, so plain text and simple escapes keep a steady
// one word per cycle while a \uXXXX escape gives its 1..4 UTF-8 bytes; the
// JOB_DEPTH-entry job queue soaks up those bursts before req_full rises. With
// the back end idle, the first result of a word goes into the job queue and
// then the output register behind the rsp_ ports. Words that only advance the
// state (quotes that open a string, backslashes, the u of an escape, hex digits
// but the one that ends a code point) give no result. rsp_last_of_run marks the
// last result caused by one input word; string_done marks the closing quote and
// error_code a failed string, after which the block waits for a new opening quote.
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int JOB_DEPTH = 4
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_marker,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_done,
   output logic [3:0] rsp_error_code,
   output logic       rsp_last_of_run
);

   logic            accept;
   logic            job_push;
   job_type         job_data;
   job_type         head;
   logic            job_pop;
   fifo_status_type status;

   // a word is taken whenever the queue has room, even if it will make no job
   assign req_full = status.full;
   assign accept   = req_push && !status.full;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .end_marker (req_end_marker),
      .job_push   (job_push),
      .job_data   (job_data)
   );

   jsu_fifo #(.DEPTH(JOB_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .head      (head),
      .status    (status)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .status          (status),
      .job_pop         (job_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
